>>> src/fel_pkg.sv
// shared constants and types for the framed energy block
package fel_pkg;
   localparam int MaxFrame   = 1024;
   localparam int SampleBits = 16;
   localparam int PtrBits    = $clog2(MaxFrame);
   localparam int LenBits    = 11;
   localparam int EnergyBits = 41;
   localparam int IndexBits  = 32;
   localparam int SquareBits = 2 * SampleBits;
   localparam int CsrIdxBits = 2;
   localparam int CsrDataBits = 11;
   localparam logic [17:0] LogCoef = 18'd197283;

   localparam logic [CsrIdxBits-1:0] CsrFrameSize  = 2'd0;
   localparam logic [CsrIdxBits-1:0] CsrFrameShift = 2'd1;
   localparam logic [CsrIdxBits-1:0] CsrNormalize  = 2'd2;
   localparam logic [CsrIdxBits-1:0] CsrLogMode    = 2'd3;

   typedef logic [EnergyBits-1:0] energy_type;
   typedef logic [IndexBits-1:0]  index_type;

   typedef struct packed {
      logic       start;
      logic       normalize;
      logic       log_en;
      energy_type sum;
      logic [LenBits-1:0] size;
   } job_type;

   // clamp a length register to 1..MaxFrame
   function automatic logic [LenBits-1:0] clamp_len(input logic [LenBits-1:0] v);
      logic [LenBits-1:0] r;
      r = v;
      if (v == '0) r = LenBits'(1);
      else if (v > LenBits'(MaxFrame)) r = LenBits'(MaxFrame);
      return r;
   endfunction
endpackage

>>> src/fel_if.sv
// valid/ready channel interfaces
interface fel_req_if;
   logic valid;
   logic ready;
   logic signed [fel_pkg::SampleBits-1:0] sample;
   logic restart;
   modport source (output valid, sample, restart, input ready);
   modport sink   (input valid, sample, restart, output ready);
endinterface

interface fel_rsp_if;
   logic valid;
   logic ready;
   logic [fel_pkg::EnergyBits-1:0] energy_value;
   logic [fel_pkg::IndexBits-1:0]  frame_start;
   modport source (output valid, energy_value, frame_start, input ready);
   modport sink   (input valid, energy_value, frame_start, output ready);
endinterface

interface fel_csr_if;
   logic valid;
   logic ready;
   logic [fel_pkg::CsrIdxBits-1:0]  index;
   logic [fel_pkg::CsrDataBits-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> src/framed_energy_log_db.sv
// top level of the framed short-time energy block
//  channel | dir | payload
//  req     | in  | sample, restart
//  rsp     | out | energy_value, frame_start
//  csr     | in  | index, data (frame_size, frame_shift, normalize_mode, log_mode)
// a sample with no frame boundary passes through accept, ring read and sum update
// a boundary item also runs fel_post: a divide when normalizing and a log
// (scan, 16 squarings, multiply, round) in log mode, before rsp goes valid
// the ring is a single-port-read memory read into a register in S_READ
// reset clears counters and the sum; the ring needs no clearing
// req is held off while a result waits on rsp
module framed_energy_log_db (
   input logic clock,
   input logic reset,
   fel_req_if.sink   req,
   fel_rsp_if.source rsp,
   fel_csr_if.sink   csr
);
   import fel_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_READ, S_SUB, S_WAIT, S_OUT} state_type;

   // configuration registers
   logic [LenBits-1:0] size_cfg_ff, shift_cfg_ff;
   logic norm_ff, log_ff;
   logic [LenBits-1:0] asize_ff, ashift_ff;

   // stream state
   energy_type sum_ff;
   index_type  count_ff, nfs_ff;
   logic [PtrBits-1:0] wptr_ff;
   logic [LenBits-1:0] fill_ff;

   // ring memory
   logic signed [SampleBits-1:0] ring [MaxFrame];
   logic signed [SampleBits-1:0] old_ff;
   logic [PtrBits-1:0] rd_addr;

   state_type state_ff;
   logic signed [SampleBits-1:0] samp_ff;
   logic emit_ff, drop_ff;
   index_type fstart_ff;
   energy_type out_ff;
   logic rsp_valid_ff;
   job_type job;
   logic post_done;
   energy_type post_result;

   logic [SquareBits-1:0] sq_new, sq_old;
   logic accept;

   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.energy_value = out_ff;
   assign rsp.frame_start = fstart_ff;
   // oldest sample of the window
   assign rd_addr = wptr_ff - PtrBits'(asize_ff);
   // widen before squaring so the full product is kept
   assign sq_new = $unsigned(SquareBits'(samp_ff) * SquareBits'(samp_ff));
   assign sq_old = $unsigned(SquareBits'(old_ff) * SquareBits'(old_ff));

   always_ff @(posedge clock) begin
      if (state_ff == S_READ) old_ff <= ring[rd_addr];
      if (state_ff == S_SUB) ring[wptr_ff] <= samp_ff;
   end

   always_ff @(posedge clock) begin
      job.start <= 1'b0;
      if (reset) begin
         size_cfg_ff  <= LenBits'(400);
         shift_cfg_ff <= LenBits'(160);
         norm_ff <= 1'b1;
         log_ff  <= 1'b1;
         asize_ff  <= LenBits'(400);
         ashift_ff <= LenBits'(160);
         sum_ff <= '0;
         count_ff <= '0;
         nfs_ff <= '0;
         wptr_ff <= '0;
         fill_ff <= '0;
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            case (csr.index)
               CsrFrameSize:  size_cfg_ff  <= csr.data;
               CsrFrameShift: shift_cfg_ff <= csr.data;
               CsrNormalize:  norm_ff <= csr.data[0];
               CsrLogMode:    log_ff  <= csr.data[0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (accept) begin
               samp_ff <= req.sample;
               if (req.restart) begin
                  // restart: clear stream, latch sizes
                  sum_ff <= '0;
                  count_ff <= '0;
                  nfs_ff <= '0;
                  wptr_ff <= '0;
                  fill_ff <= '0;
                  asize_ff  <= clamp_len(size_cfg_ff);
                  ashift_ff <= clamp_len(shift_cfg_ff);
               end
               state_ff <= S_READ;
            end
            S_READ: begin
               emit_ff <= (count_ff - nfs_ff) == IndexBits'(asize_ff);
               drop_ff <= fill_ff >= asize_ff;
               state_ff <= S_SUB;
            end
            S_SUB: begin
               fstart_ff <= nfs_ff;
               if (emit_ff) begin
                  job.start <= 1'b1;
                  job.sum <= sum_ff;
                  job.size <= asize_ff;
                  job.normalize <= norm_ff;
                  job.log_en <= log_ff;
                  nfs_ff <= nfs_ff + IndexBits'(ashift_ff);
               end
               sum_ff <= sum_ff - (drop_ff ? EnergyBits'(sq_old) : '0)
                         + EnergyBits'(sq_new);
               if (!drop_ff) fill_ff <= fill_ff + LenBits'(1);
               wptr_ff <= wptr_ff + PtrBits'(1);
               count_ff <= count_ff + IndexBits'(1);
               state_ff <= emit_ff ? S_WAIT : S_IDLE;
            end
            S_WAIT: if (post_done) begin
               out_ff <= post_result;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   fel_post u_post (
      .clock(clock), .reset(reset), .job(job),
      .done(post_done), .result(post_result)
   );
endmodule

>>> src/fel_post.sv
// serial unit shared by an optional restoring divide and an optional log2 by repeated squaring
module fel_post (
   input  logic                  clock,
   input  logic                  reset,
   input  fel_pkg::job_type      job,
   output logic                  done,
   output fel_pkg::energy_type   result
);
   import fel_pkg::*;

   typedef enum logic [2:0] {IDLE, DIV, NORM, SQR, MUL, FIN} state_type;

   state_type state_ff;
   logic [5:0] cnt_ff;
   energy_type quo_ff;
   logic [LenBits:0] rem_ff;
   logic [5:0] k_ff;
   logic [31:0] m_ff;
   logic [15:0] frac_ff;
   logic [39:0] prod_ff;
   logic done_ff;
   logic log_ff;
   logic [LenBits-1:0] size_ff;

   logic [LenBits:0] rem_sh;
   logic [63:0] sq;
   logic [21:0] lval;
   logic [5:0] top_bit;
   logic [31:0] m_init;

   assign rem_sh = {rem_ff[LenBits-1:0], quo_ff[EnergyBits-1]};
   assign sq = 64'(m_ff) * 64'(m_ff);
   assign lval = {k_ff, frac_ff};
   assign done = done_ff;
   assign result = quo_ff;

   // top bit position found by a priority scan of the word
   always_comb begin
      top_bit = '0;
      for (int i = 0; i < EnergyBits; i++) begin
         if (quo_ff[i]) top_bit = 6'(i);
      end
      if (top_bit >= 6'd31) m_init = 32'(quo_ff >> (top_bit - 6'd31));
      else m_init = 32'(quo_ff << (6'd31 - top_bit));
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         case (state_ff)
            IDLE: if (job.start) begin
               quo_ff  <= job.sum;
               rem_ff  <= '0;
               size_ff <= job.size;
               log_ff  <= job.log_en;
               cnt_ff  <= 6'(EnergyBits);
               if (job.normalize) state_ff <= DIV;
               else if (job.log_en) state_ff <= NORM;
               else begin
                  done_ff <= 1'b1;
               end
               if (!job.normalize && !job.log_en) state_ff <= IDLE;
            end
            DIV: begin
               // one quotient bit per cycle
               if (rem_sh >= {1'b0, size_ff}) begin
                  rem_ff <= rem_sh - {1'b0, size_ff};
                  quo_ff <= {quo_ff[EnergyBits-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= {quo_ff[EnergyBits-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) begin
                  if (log_ff) state_ff <= NORM;
                  else begin
                     state_ff <= IDLE;
                     done_ff  <= 1'b1;
                  end
               end
            end
            NORM: begin
               if (quo_ff == '0) begin
                  state_ff <= IDLE;
                  done_ff  <= 1'b1;
               end else begin
                  k_ff     <= top_bit;
                  m_ff     <= m_init;
                  state_ff <= SQR;
                  cnt_ff   <= 6'd16;
                  frac_ff  <= '0;
               end
            end
            SQR: begin
               if (sq[63]) begin
                  m_ff    <= sq[63:32];
                  frac_ff <= {frac_ff[14:0], 1'b1};
               end else begin
                  m_ff    <= sq[62:31];
                  frac_ff <= {frac_ff[14:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) state_ff <= MUL;
            end
            MUL: begin
               prod_ff  <= 40'(lval) * 40'(LogCoef) + 40'(1 << 23);
               state_ff <= FIN;
            end
            FIN: begin
               quo_ff   <= EnergyBits'(prod_ff >> 24);
               done_ff  <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

>>> src/fel_check.sv
// port-level checks on the framed energy block
module fel_check (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("req taken with result pending");
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready too soon");
endmodule

bind framed_energy_log_db fel_check u_check (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready)
);
